[rtl/grid_min_cost_path_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the grid minimum cost path block
// Shared helpers that clock on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_MIN_COST_PATH_TOP_MACROS_SVH
`define GRID_MIN_COST_PATH_TOP_MACROS_SVH

// Same-cycle implication.
`define GMCP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GMCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gmcp_pkg.sv]
// ----------------------------------------------------------------------------
// Grid minimum cost path package
// Widths, register indexes, direction codes and dimension clamping.
// ----------------------------------------------------------------------------
package gmcp_pkg;

    localparam int unsigned MAX_WIDTH   = 1024;
    localparam int unsigned MAX_HEIGHT  = 1024;
    localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT);
    localparam int unsigned DIM_W       = 11;
    localparam int unsigned CELL_W      = 16;
    localparam int unsigned COST_W      = 27;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        FROM_START = 2'd0,
        FROM_LEFT  = 2'd1,
        FROM_ABOVE = 2'd2
    } came_from_t;

    // Last usable position for a dimension: zero counts as one, large values
    // saturate at the maximum.
    function automatic int unsigned dim_last(input logic [DIM_W-1:0] v,
                                             input int unsigned maxv);
        int unsigned vi;
        vi = 32'(v);
        if (vi == 0) begin
            return 0;
        end
        if (vi > maxv) begin
            return maxv - 1;
        end
        return vi - 1;
    endfunction

endpackage

[rtl/gmcp_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gmcp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/grid_min_cost_path_top.sv]
// ----------------------------------------------------------------------------
// Grid minimum cost path
// Streams cell costs in row-major order and returns, per cell, the least
// cost of a right/down path from the top-left cell and the step it came from.
// ----------------------------------------------------------------------------
// The block takes one cell beat per clock while in_stall is low and returns one
// result beat per cell; each cell passes through the stage-1 registers and then
// the result register. The row store, a RAM with registered read, holds the
// previous row's costs: the entry above is read when a cell is accepted and the
// new cost is written back when the cell leaves stage 1, with a bypass for
// one-column grids. The row store needs no clearing after reset.
// A write to grid_width or grid_height restarts at the top-left cell.
`include "grid_min_cost_path_top_macros.svh"

module grid_min_cost_path_top
    import gmcp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [CELL_W-1:0]      cell_cost,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COST_W-1:0]      path_cost,
    output logic [1:0]             came_from,
    output logic                   last_cell
);

    logic [COL_W-1:0]  width_last_reg;
    logic [ROW_W-1:0]  height_last_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COST_W-1:0] left_cost_reg;

    logic              s1_valid_reg;
    logic [CELL_W-1:0] s1_cell_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_row0_reg;
    logic              s1_last_reg;
    logic              s1_fwd_reg;
    logic [COST_W-1:0] s1_fwd_data_reg;

    logic              out_valid_reg;
    logic [COST_W-1:0] path_cost_reg;
    came_from_t        came_from_reg;
    logic              last_cell_reg;

    logic              in_accept;
    logic              s1_advance;
    logic [COST_W-1:0] ram_rd_data;
    logic [COST_W-1:0] up_cost;
    logic [COST_W-1:0] base_cost;
    logic [COST_W:0]   sum_cost;
    logic [COST_W-1:0] new_cost;
    came_from_t        new_from;
    logic              s1_col0;

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    gmcp_ram #(
        .WIDTH (COST_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data (new_cost),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    assign up_cost = s1_fwd_reg ? s1_fwd_data_reg : ram_rd_data;
    assign s1_col0 = (s1_col_reg == '0);

    always_comb
    begin
        if (s1_row0_reg && s1_col0)
        begin
            base_cost = '0;
            new_from  = FROM_START;
        end
        else if (s1_row0_reg)
        begin
            base_cost = left_cost_reg;
            new_from  = FROM_LEFT;
        end
        else if (s1_col0)
        begin
            base_cost = up_cost;
            new_from  = FROM_ABOVE;
        end
        else if (up_cost > left_cost_reg)
        begin
            base_cost = left_cost_reg;
            new_from  = FROM_LEFT;
        end
        else
        begin
            base_cost = up_cost;
            new_from  = FROM_ABOVE;
        end
        sum_cost = {1'b0, base_cost} + (COST_W + 1)'(s1_cell_reg);
        new_cost = sum_cost[COST_W] ? '1 : sum_cost[COST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg  <= COL_W'(dim_last(DIM_RESET, MAX_WIDTH));
            height_last_reg <= ROW_W'(dim_last(DIM_RESET, MAX_HEIGHT));
            col_reg         <= '0;
            row_reg         <= '0;
            left_cost_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            s1_fwd_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH:
                    begin
                        width_last_reg <= COL_W'(dim_last(cfg_data, MAX_WIDTH));
                        col_reg        <= '0;
                        row_reg        <= '0;
                        left_cost_reg  <= '0;
                    end
                    CFG_GRID_HEIGHT:
                    begin
                        height_last_reg <= ROW_W'(dim_last(cfg_data, MAX_HEIGHT));
                        col_reg         <= '0;
                        row_reg         <= '0;
                        left_cost_reg   <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (in_accept)
            begin
                if (col_reg == width_last_reg)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == height_last_reg) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end

            if (s1_advance)
            begin
                left_cost_reg <= new_cost;
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_fwd_reg   <= s1_advance && (s1_col_reg == col_reg);
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
                s1_fwd_reg   <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cell_reg     <= cell_cost;
            s1_col_reg      <= col_reg;
            s1_row0_reg     <= (row_reg == '0);
            s1_last_reg     <= (row_reg == height_last_reg) && (col_reg == width_last_reg);
            s1_fwd_data_reg <= new_cost;
        end
        if (s1_advance)
        begin
            path_cost_reg <= new_cost;
            came_from_reg <= new_from;
            last_cell_reg <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign path_cost = path_cost_reg;
    assign came_from = came_from_reg;
    assign last_cell = last_cell_reg;

    `GMCP_ASSERT_IMPL(a_no_overwrite, out_valid_reg && out_stall, !s1_advance,
        "Result register overwritten while the output is stalled.")
    `GMCP_ASSERT_NEXT(a_cost_covers_cell, s1_advance,
        out_valid_reg && (path_cost_reg >= COST_W'($past(s1_cell_reg))),
        "Path cost is below the cost of its own cell.")
    `GMCP_ASSERT_IMPL(a_left_needs_column, s1_advance && (new_from == FROM_LEFT),
        !s1_col0, "A first-column cell was taken from the left.")

endmodule

[tb/grid_min_cost_path_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the grid minimum cost path block
// Streams cell costs through grids of many shapes, from one cell up to the
// widest and tallest settings, and checks each result beat against a
// predictor that tracks the row store, the left cost and the grid position.
// Both sides idle and stall at random, phase by phase.
// ----------------------------------------------------------------------------
module grid_min_cost_path_top_test;
    import gmcp_pkg::*;

    localparam int unsigned COST_LIMIT = (1 << COST_W) - 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = CFG_INDEX_W'(3);
    localparam int COST_ANY     = 0;
    localparam int COST_TIES    = 1;
    localparam int COST_EXTREME = 2;
    localparam int COST_MIXED   = 3;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        came_from_t        dir;
        logic              last;
    } path_step_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [CELL_W-1:0]      cell_cost = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [COST_W-1:0]      path_cost;
    logic [1:0]             came_from;
    logic                   last_cell;

    logic [CELL_W-1:0] cells_to_send[$];
    path_step_t        expected_steps[$];
    int                cells_queued = 0;
    int                results_seen = 0;
    int                grids_finished = 0;
    int                writes_done = 0;
    int                errors = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;

    int unsigned      row_store[MAX_WIDTH];
    int unsigned      left_acc = 0;
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;
    logic [DIM_W-1:0] width_reg = DIM_RESET;
    logic [DIM_W-1:0] height_reg = DIM_RESET;

    grid_min_cost_path_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cell_cost (cell_cost),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .path_cost (path_cost),
        .came_from (came_from),
        .last_cell (last_cell)
    );

    always #5 clk = ~clk;

    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v,
                                            input int unsigned maxv);
        if (v == 0)
        begin
            return 1;
        end
        if (32'(v) > maxv)
        begin
            return maxv;
        end
        return 32'(v);
    endfunction

    function automatic path_step_t next_path_step(input logic [CELL_W-1:0] c);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        int unsigned base;
        int unsigned acc;
        path_step_t  s;
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        col = (col_pos >= w) ? w - 1 : col_pos;
        row = (row_pos >= h) ? h - 1 : row_pos;
        if (row == 0 && col == 0)
        begin
            base = 0;
            s.dir = FROM_START;
        end
        else if (row == 0)
        begin
            base = left_acc;
            s.dir = FROM_LEFT;
        end
        else if (col == 0 || row_store[col] <= left_acc)
        begin
            base = row_store[col];
            s.dir = FROM_ABOVE;
        end
        else
        begin
            base = left_acc;
            s.dir = FROM_LEFT;
        end
        acc = base + 32'(c);
        if (acc > COST_LIMIT)
        begin
            acc = COST_LIMIT;
        end
        row_store[col] = acc;
        left_acc = acc;
        s.cost = acc[COST_W-1:0];
        s.last = (row == h - 1) && (col == w - 1);
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
            begin
                row = 0;
            end
        end
        col_pos = col;
        row_pos = row;
        return s;
    endfunction

    function automatic logic [CELL_W-1:0] pick_cost(input int style);
        int s;
        s = (style == COST_MIXED) ? $urandom_range(COST_EXTREME) : style;
        case (s)
            COST_TIES:    return CELL_W'($urandom_range(3));
            COST_EXTREME: return $urandom_range(1) ? '1 : '0;
            default:      return CELL_W'($urandom);
        endcase
    endfunction

    task automatic queue_cell(input logic [CELL_W-1:0] c);
        cells_to_send.push_back(c);
        cells_queued++;
    endtask

    task automatic set_pace(input int mode);
        case (mode % 4)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 80;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 80;
            end
            default:
            begin
                send_idle_pct = 19;
                recv_stall_pct = 19;
            end
        endcase
    endtask

    task automatic wait_drained();
        while (results_seen < cells_queued)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_GRID_WIDTH || idx == CFG_GRID_HEIGHT)
        begin
            if (idx == CFG_GRID_WIDTH)
            begin
                width_reg = val;
            end
            else
            begin
                height_reg = val;
            end
            col_pos = 0;
            row_pos = 0;
            left_acc = 0;
        end
        writes_done++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cell_cost <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_steps.push_back(next_path_step(cell_cost));
            end
            if (!in_valid || !in_stall)
            begin
                if (cells_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    cell_cost <= cells_to_send.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                    cell_cost <= CELL_W'($urandom);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        path_step_t exp;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (last_cell)
                begin
                    grids_finished++;
                end
                if (expected_steps.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("beat %0d: unexpected result, cost %0d from %0d last %0d",
                                 results_seen, path_cost, came_from, last_cell);
                    end
                end
                else
                begin
                    exp = expected_steps.pop_front();
                    if (path_cost !== exp.cost || came_from !== exp.dir
                        || last_cell !== exp.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("beat %0d: expected cost %0d from %0d last %0d, ",
                                     results_seen, exp.cost, exp.dir, exp.last,
                                     "got cost %0d from %0d last %0d",
                                     path_cost, came_from, last_cell);
                        end
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        logic [CELL_W-1:0] corner_cells[9];
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        int                random_cells;
        int                phase;
        int                area;
        int                n;
        int                style;
        corner_cells = '{16'd0, 16'hFFFF, 16'd5, 16'd1, 16'd2, 16'd3, 16'd4, 16'd3, 16'hFFFF};
        random_cells = 0;
        phase = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // A 3x3 grid with every direction, a tie between above and left,
        // and the cost extremes; then one-cell, one-column and one-row grids.
        set_grid(DIM_W'(3), DIM_W'(3));
        foreach (corner_cells[i])
        begin
            queue_cell(corner_cells[i]);
        end
        wait_drained();
        set_grid(DIM_W'(0), DIM_W'(0));
        queue_cell('1);
        queue_cell('0);
        wait_drained();
        set_grid(DIM_W'(1), DIM_W'(4));
        repeat (4) queue_cell(pick_cost(COST_EXTREME));
        wait_drained();
        set_grid(DIM_W'(4), DIM_W'(1));
        repeat (4) queue_cell(pick_cost(COST_ANY));
        wait_drained();

        while (random_cells < 400)
        begin
            set_pace(phase);
            case ($urandom_range(19))
                0:       w = '0;
                1:       w = DIM_W'($urandom_range(1025, 2047));
                2, 3:    w = DIM_W'($urandom_range(9, 32));
                default: w = DIM_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(19))
                0:       h = '0;
                1:       h = DIM_W'($urandom_range(1025, 2047));
                2, 3:    h = DIM_W'($urandom_range(9, 32));
                default: h = DIM_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(9))
                0: ;
                1: write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                             DIM_W'($urandom_range(2047)));
                2: write_reg(CFG_GRID_WIDTH, w);
                3: write_reg(CFG_GRID_HEIGHT, h);
                default:
                begin
                    if ($urandom_range(1))
                    begin
                        set_grid(w, h);
                    end
                    else
                    begin
                        write_reg(CFG_GRID_HEIGHT, h);
                        write_reg(CFG_GRID_WIDTH, w);
                    end
                end
            endcase
            area = eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT);
            if (area <= 64)
            begin
                n = $urandom_range(1, 3) * area;
                if ($urandom_range(3) == 0)
                begin
                    n += $urandom_range(area - 1);
                end
            end
            else
            begin
                n = $urandom_range(10, 60);
            end
            style = $urandom_range(COST_MIXED);
            repeat (n) queue_cell(pick_cost(style));
            random_cells += n;
            phase++;
            wait_drained();
        end

        // The widest row, the tallest column and the exact maximum
        // settings, each in part.
        set_pace(3);
        set_grid(DIM_W'(2047), DIM_W'(1));
        repeat (60) queue_cell(pick_cost(COST_MIXED));
        wait_drained();
        set_pace(0);
        set_grid(DIM_W'(1), DIM_W'(2047));
        repeat (60) queue_cell(pick_cost(COST_EXTREME));
        wait_drained();
        set_grid(DIM_W'(MAX_WIDTH), DIM_W'(MAX_HEIGHT));
        repeat (60) queue_cell(pick_cost(COST_TIES));
        wait_drained();
        repeat (10) @(posedge clk);

        if (expected_steps.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_steps.size());
            errors += expected_steps.size();
        end
        $display("Checked %0d cells over %0d register writes; %0d grids ran to the last cell.",
                 results_seen, writes_done, grids_finished);
        $display("Mismatches: %0d.", errors);
        if (errors == 0)
        begin
            $display("[grid_min_cost_path_top] OK");
        end
        else
        begin
            $display("[grid_min_cost_path_top] ERROR");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timed out with %0d of %0d results received.", results_seen, cells_queued);
        $display("[grid_min_cost_path_top] ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/gmcp_pkg.sv
rtl/gmcp_ram.sv
rtl/grid_min_cost_path_top.sv
tb/grid_min_cost_path_top_test.sv
